// ----- src/f2u16_pkg.sv -----
// package: beat types and constants for the float to u16 converter
package f2u16_pkg;

	localparam int unsigned ValueW = 16;
	localparam logic [7:0] ExpAllOnes = 8'hFF;
	localparam logic [7:0] ExpHalf = 8'd126;
	localparam logic [7:0] ExpTop = 8'd143;
	localparam logic [30:0] MagQuarter = 31'h3E800000;

	typedef struct packed {
		logic [31:0] float_bits;
		logic        last_in;
	} in_beat_t;

	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              item_out_of_range;
		logic              batch_error;
		logic              last_out;
	} out_beat_t;

	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              err;
	} conv_res_t;

endpackage

// ----- src/f2u16_round.sv -----
// module: combinational round-to-nearest-even conversion of one float word
module f2u16_round (
	input  logic [31:0]          bits,
	output f2u16_pkg::conv_res_t res
);
	import f2u16_pkg::*;

	logic        sign;
	logic [7:0]  expo;
	logic [23:0] mant;
	logic [4:0]  shift;
	logic [23:0] whole;
	logic [23:0] rem;
	logic [23:0] half;
	logic        rnd;
	logic [24:0] sum;

	assign sign = bits[31];
	assign expo = bits[30:23];
	assign mant = {1'b1, bits[22:0]};
	assign shift = 5'(8'd150 - expo);
	assign whole = mant >> shift;
	assign rem = mant & ((24'd1 << shift) - 24'd1);
	assign half = 24'd1 << (shift - 5'd1);
	assign rnd = (rem > half) || ((rem == half) && whole[0]);
	assign sum = {1'b0, whole} + {24'd0, rnd};

	always_comb begin
		res = '0;
		priority if (expo == ExpAllOnes) begin
			res.err = 1'b1;
		end else if (sign) begin
			res.err = !(bits[30:0] <= MagQuarter);
		end else if (expo < ExpHalf) begin
			res.err = 1'b0;
		end else if (expo > ExpTop) begin
			res.err = 1'b1;
		end else if (sum[24:ValueW] != '0) begin
			res.err = 1'b1;
		end else begin
			res.value = sum[ValueW-1:0];
		end
	end

endmodule

// ----- src/float_to_u16_round_convert.sv -----
// top level: float to u16 round-nearest-even converter with sticky batch error
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_data  (float_bits, last_in)
//  output  | out_valid | out_stall | out_data (value, flags, last_out)
// one beat per cycle unless a full output is stalled; each beat passes the input register, then the
// combinational rounder, then the result register
// the sticky error updates as each beat leaves the input register
// reset clears valids and sticky error; in_stall follows a full, stalled pipe
module float_to_u16_round_convert (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  f2u16_pkg::in_beat_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output f2u16_pkg::out_beat_t  out_data
);
	import f2u16_pkg::*;

	in_beat_t  data_s1;
	logic      valid_s1;
	logic      sticky_q;
	conv_res_t res;
	logic      adv_s1;
	logic      batch;

	f2u16_round u_round (
		.bits(data_s1.float_bits),
		.res (res)
	);

	assign adv_s1 = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign batch = sticky_q | res.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			sticky_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				out_valid <= 1'b1;
				sticky_q <= data_s1.last_in ? 1'b0 : batch;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data.value <= res.value;
			out_data.item_out_of_range <= res.err;
			out_data.batch_error <= batch;
			out_data.last_out <= data_s1.last_in;
		end
	end

`ifndef SYNTH
	a_zero_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.item_out_of_range |-> out_data.value == '0)
		else $error("flagged beat carries nonzero value");
	a_batch_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.item_out_of_range |-> out_data.batch_error)
		else $error("batch error misses item flag");
	a_sticky_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && data_s1.last_in |=> !sticky_q)
		else $error("sticky error not cleared after last beat");
`endif

endmodule
